// ===== src/pts_pkg.sv =====
// Shared types and codes for the process table scheduler.
package pts_pkg;

  // Stream word widths (byte padded)
  localparam int IN_W  = 24;  // action 2, kill_pid 16, load_ok 1
  localparam int OUT_W = 40;  // status 2, new_pid 16, current_valid 1, slot 3, pid 16

  // Field widths fixed by the interface
  localparam int PID_OUT_W  = 16;
  localparam int SLOT_OUT_W = 3;

  typedef enum logic [1:0] {
    ACT_CREATE   = 2'd0,
    ACT_KILL     = 2'd1,
    ACT_SCHEDULE = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_LOAD_FAIL = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Per-slot process state codes
  localparam logic [1:0] PS_READY   = 2'd0;
  localparam logic [1:0] PS_RUNNING = 2'd1;
  localparam logic [1:0] PS_DEAD    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;  // capture the input word
    logic scan;     // register the slot match vectors
    logic exec;     // apply the action and load the result word
  } pts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;  // result register holds a word not yet taken
  } pts_stat_t;

endpackage

// ===== src/pts_ctrl.sv =====
// Controller: sequences capture, slot scan and execute for each word.
module pts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  pts_pkg::pts_stat_t   stat,
  output pts_pkg::pts_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    SCAN = 3'b010,
    EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = SCAN;
        end
      end
      SCAN: begin
        cmd.scan   = 1'b1;
        state_next = EXEC;
      end
      EXEC: begin
        // wait here while the previous result is still held
        if (!stat.out_busy) begin
          cmd.exec = 1'b1;
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.load_in = 1'b1;
            state_next  = SCAN;
          end else begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

// ===== src/pts_dp.sv =====
// Datapath: process table, current selection, pid counter and result register.
module pts_dp #(
  parameter int TABLE_SLOTS = 8,
  parameter int PID_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pts_pkg::pts_cmd_t           cmd,
  output pts_pkg::pts_stat_t          stat,
  input  logic [pts_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pts_pkg::OUT_W-1:0]   m_tdata
);

  localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW  = (PID_BITS > pts_pkg::PID_OUT_W) ? PID_BITS : pts_pkg::PID_OUT_W;
  localparam int OSW = (SW > pts_pkg::SLOT_OUT_W) ? SW : pts_pkg::SLOT_OUT_W;

  // Table
  logic [TABLE_SLOTS-1:0] slot_used;
  logic [1:0]             slot_state [TABLE_SLOTS];
  logic [PID_BITS-1:0]    slot_pid   [TABLE_SLOTS];
  logic                   cur_valid;
  logic [SW-1:0]          cur_slot;
  logic [PID_BITS-1:0]    next_pid;

  // Captured input word
  pts_pkg::action_t             in_act;
  logic [pts_pkg::PID_OUT_W-1:0] in_kpid;
  logic                         in_ok;

  // Scan stage
  pts_pkg::action_t       sc_act;
  logic                   sc_ok;
  logic [TABLE_SLOTS-1:0] free_vec, match_vec, ready_vec;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_act  <= pts_pkg::action_t'(s_tdata[1:0]);
      in_kpid <= s_tdata[17:2];
      in_ok   <= s_tdata[18];
    end
  end

  // Per-slot compares, registered
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      sc_act <= in_act;
      sc_ok  <= in_ok;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        free_vec[i]  <= !slot_used[i];
        match_vec[i] <= slot_used[i] && (CW'(slot_pid[i]) == CW'(in_kpid));
        ready_vec[i] <= slot_used[i] && (slot_state[i] == pts_pkg::PS_READY);
      end
    end
  end

  // Lowest set bit of each vector
  logic [SW-1:0] free_idx, match_idx, ready_idx;
  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    ready_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i])  free_idx  = SW'(i);
      if (match_vec[i]) match_idx = SW'(i);
      if (ready_vec[i]) ready_idx = SW'(i);
    end
  end

  // Action decode
  logic                         cur_valid_next;
  logic [SW-1:0]                cur_slot_next;
  pts_pkg::status_t             status;
  logic [pts_pkg::PID_OUT_W-1:0] npid;
  logic                         keep_cur;
  always_comb begin
    cur_valid_next = cur_valid;
    cur_slot_next  = cur_slot;
    status         = pts_pkg::ST_OK;
    npid           = '0;
    keep_cur       = cur_valid && ready_vec[cur_slot];
    case (sc_act)
      pts_pkg::ACT_CREATE: begin
        if (free_vec == '0) begin
          status = pts_pkg::ST_FULL;
        end else if (sc_ok) begin
          npid = pts_pkg::PID_OUT_W'(CW'(next_pid));
        end else begin
          status = pts_pkg::ST_LOAD_FAIL;
        end
      end
      pts_pkg::ACT_KILL: begin
        if (match_vec == '0) begin
          status = pts_pkg::ST_NOT_FOUND;
        end else if (cur_valid && cur_slot == match_idx) begin
          cur_valid_next = 1'b0;
          cur_slot_next  = '0;
        end
      end
      pts_pkg::ACT_SCHEDULE: begin
        if (!keep_cur) begin
          cur_valid_next = (ready_vec != '0);
          cur_slot_next  = (ready_vec != '0) ? ready_idx : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Table and selection update
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      cur_valid <= 1'b0;
      cur_slot  <= '0;
      next_pid  <= PID_BITS'(1);
      for (int i = 0; i < TABLE_SLOTS; i++) slot_state[i] <= pts_pkg::PS_READY;
    end else if (cmd.exec) begin
      cur_valid <= cur_valid_next;
      cur_slot  <= cur_slot_next;
      case (sc_act)
        pts_pkg::ACT_CREATE: begin
          if (free_vec != '0) begin
            slot_pid[free_idx]   <= next_pid;
            slot_state[free_idx] <= pts_pkg::PS_READY;
            slot_used[free_idx]  <= sc_ok;
            next_pid             <= next_pid + PID_BITS'(1);
          end
        end
        pts_pkg::ACT_KILL: begin
          if (match_vec != '0) begin
            slot_used[match_idx]  <= 1'b0;
            slot_state[match_idx] <= pts_pkg::PS_DEAD;
          end
        end
        pts_pkg::ACT_DISPATCH: begin
          if (cur_valid && slot_used[cur_slot]) slot_state[cur_slot] <= pts_pkg::PS_RUNNING;
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields; the current slot is never one that a create writes
  logic [CW-1:0]  cur_pid_w;
  logic [OSW-1:0] cur_slot_w;
  assign cur_pid_w  = cur_valid_next ? CW'(slot_pid[cur_slot_next]) : '0;
  assign cur_slot_w = cur_valid_next ? OSW'(cur_slot_next) : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      m_tdata <= {2'b00,
                  cur_pid_w[pts_pkg::PID_OUT_W-1:0],
                  cur_slot_w[pts_pkg::SLOT_OUT_W-1:0],
                  cur_valid_next,
                  npid,
                  status};
    end
  end

  assign stat.out_busy = m_tvalid && !m_tready;

endmodule

// ===== src/process_table_scheduler.sv =====
// A result word is registered in execute, after its input word is captured and scanned.
// A new word is taken only once the last one reaches execute (capture, then slot scan and
// execute), limited by the registered per-slot compare ahead of the priority pick.
// The next word is taken while a result waits; execute stalls if it is untaken.
// Synchronous reset clears the table, drops the current process and sets pid to 1.
module process_table_scheduler #(
  parameter int TABLE_SLOTS = 8,
  parameter int PID_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // s_tdata: action[1:0], kill_pid[17:2], load_ok[18], zero pad
  input  logic [pts_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // m_tdata: status[1:0], new_pid[17:2], current_valid[18],
  //          current_slot[21:19], current_pid[37:22], zero pad
  output logic [pts_pkg::OUT_W-1:0] m_tdata
);

  pts_pkg::pts_cmd_t  cmd;
  pts_pkg::pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pts_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .PID_BITS    (PID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the process table scheduler stream block.
`timescale 1ns / 1ps

module testbench;

  localparam int N_SLOTS = 8;
  localparam int N_DIR   = 25;

  // one result word, unpacked
  typedef struct packed {
    pts_pkg::status_t status;
    logic [15:0]      new_pid;
    logic             cur_valid;
    logic [2:0]       cur_slot;
    logic [15:0]      cur_pid;
  } sched_result_t;

  // one directed command, with an optional hand-typed answer
  typedef struct packed {
    pts_pkg::action_t act;
    logic [15:0]      kpid;
    logic             ok;
    logic             typed;
    sched_result_t    want;
  } cmd_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [pts_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [pts_pkg::OUT_W-1:0] m_tdata;

  // shadow copy of the process table
  logic        tbl_used  [N_SLOTS];
  logic [1:0]  tbl_state [N_SLOTS];
  logic [15:0] tbl_pid   [N_SLOTS];
  logic        sel_valid;
  logic [2:0]  sel_slot;
  logic [15:0] pid_next;

  sched_result_t result_q[$];
  int          mismatch_cnt = 0;
  int          burst_left = 0;
  bit          fast = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          rx_left = 0;

  process_table_scheduler u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit: 100 ms, several times the slowest legal run
  initial begin
    #(100_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic slot_ready(int i);
    return tbl_used[i] && tbl_state[i] == pts_pkg::PS_READY;
  endfunction

  // apply one command to the shadow table and return the result word
  function automatic sched_result_t run_table_cmd(pts_pkg::action_t act, logic [15:0] kpid,
                                                  logic ok);
    sched_result_t r;
    int hit;
    r = '0;
    r.status = pts_pkg::ST_OK;
    hit = -1;
    case (act)
      pts_pkg::ACT_CREATE: begin
        for (int i = 0; i < N_SLOTS; i++)
          if (hit < 0 && !tbl_used[i]) hit = i;
        if (hit < 0) begin
          r.status = pts_pkg::ST_FULL;
        end else begin
          tbl_pid[hit]   = pid_next;
          tbl_state[hit] = pts_pkg::PS_READY;
          pid_next       = pid_next + 16'd1;
          if (ok) begin
            tbl_used[hit] = 1'b1;
            r.new_pid     = tbl_pid[hit];
          end else begin
            tbl_used[hit] = 1'b0;
            r.status      = pts_pkg::ST_LOAD_FAIL;
          end
        end
      end
      pts_pkg::ACT_KILL: begin
        r.status = pts_pkg::ST_NOT_FOUND;
        for (int i = 0; i < N_SLOTS; i++)
          if (hit < 0 && tbl_used[i] && tbl_pid[i] == kpid) hit = i;
        if (hit >= 0) begin
          tbl_used[hit]  = 1'b0;
          tbl_state[hit] = pts_pkg::PS_DEAD;
          if (sel_valid && sel_slot == hit) begin
            sel_valid = 1'b0;
            sel_slot  = '0;
          end
          r.status = pts_pkg::ST_OK;
        end
      end
      pts_pkg::ACT_SCHEDULE: begin
        // keep the current one while it is still ready
        if (!(sel_valid && slot_ready(sel_slot))) begin
          sel_valid = 1'b0;
          sel_slot  = '0;
          for (int i = 0; i < N_SLOTS; i++)
            if (!sel_valid && slot_ready(i)) begin
              sel_valid = 1'b1;
              sel_slot  = i[2:0];
            end
        end
      end
      default: begin
        if (sel_valid && tbl_used[sel_slot]) tbl_state[sel_slot] = pts_pkg::PS_RUNNING;
      end
    endcase
    r.cur_valid = sel_valid;
    r.cur_slot  = sel_valid ? sel_slot : 3'd0;
    r.cur_pid   = sel_valid ? tbl_pid[sel_slot] : 16'd0;
    return r;
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // mostly a live pid, sometimes a stale one, an extreme or plain noise
  function automatic logic [15:0] pick_kill_pid();
    logic [15:0] live[$];
    int roll;
    for (int i = 0; i < N_SLOTS; i++)
      if (tbl_used[i]) live.push_back(tbl_pid[i]);
    roll = $urandom_range(0, 99);
    if (roll < 65 && live.size() != 0) return live[$urandom_range(0, live.size() - 1)];
    if (roll < 75) return tbl_pid[$urandom_range(0, N_SLOTS - 1)];
    if (roll < 80) return 16'h0000;
    if (roll < 85) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // drop valid and clear the data, then idle for the given wait
  task automatic rest(int n);
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (n) @(posedge clk);
  endtask

  // offer one word, wait for the handshake, then record what must come back
  task automatic push_word(pts_pkg::action_t act, logic [15:0] kpid, logic ok,
                           logic typed = 1'b0, sched_result_t want = '0);
    sched_result_t r;
    // bursty sender: the gap, if any, comes ahead of the word
    if (!fast) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        rest($urandom_range(1, 6));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, ok, kpid, act};
    do @(posedge clk); while (!s_tready);
    r = run_table_cmd(act, kpid, ok);
    result_q.push_back(typed ? want : r);
  endtask

  task automatic send_random_cmd(int create_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < create_pct)
      push_word(pts_pkg::ACT_CREATE, 16'($urandom_range(0, 65535)),
                $urandom_range(0, 4) != 0);
    else if (roll < create_pct + (100 - create_pct) * 4 / 10)
      push_word(pts_pkg::ACT_KILL, pick_kill_pid(), 1'($urandom_range(0, 1)));
    else if (roll < create_pct + (100 - create_pct) * 7 / 10)
      push_word(pts_pkg::ACT_SCHEDULE, 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
    else
      push_word(pts_pkg::ACT_DISPATCH, 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)));
  endtask

  // stop offering and wait until every expected word is back
  task automatic drain();
    rest(1);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 120;
      m_tready  <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(30, 200);
      end else begin
        rx_left = rx_left - 1;
      end
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= $urandom_range(0, 4) != 0;
        default: m_tready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    sched_result_t got;
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status    = pts_pkg::status_t'(m_tdata[1:0]);
      got.new_pid   = m_tdata[17:2];
      got.cur_valid = m_tdata[18];
      got.cur_slot  = m_tdata[21:19];
      got.cur_pid   = m_tdata[37:22];
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result word, expected none, actual %0h", $time, m_tdata);
      end else begin
        want = result_q.pop_front();
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("new_pid", want.new_pid, got.new_pid);
        check_field("current_valid", 16'(want.cur_valid), 16'(got.cur_valid));
        check_field("current_slot", 16'(want.cur_slot), 16'(got.cur_slot));
        check_field("current_pid", want.cur_pid, got.cur_pid);
      end
    end
  end

  // directed commands; typed answers where the table state is obvious
  cmd_row_t dir_rows [N_DIR];

  initial begin : stimulus
    logic [15:0] keep_pid;
    for (int i = 0; i < N_SLOTS; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_state[i] = pts_pkg::PS_READY;
      tbl_pid[i]   = '0;
    end
    sel_valid = 1'b0;
    sel_slot  = '0;
    pid_next  = 16'd1;

    dir_rows = '{
      '{pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0, 1'b1,
        '{pts_pkg::ST_OK, 16'd0, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_DISPATCH, 16'h0000, 1'b0, 1'b1,
        '{pts_pkg::ST_OK, 16'd0, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_KILL, 16'h0000, 1'b0, 1'b1,
        '{pts_pkg::ST_NOT_FOUND, 16'd0, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_KILL, 16'hFFFF, 1'b1, 1'b1,
        '{pts_pkg::ST_NOT_FOUND, 16'd0, 1'b0, 3'd0, 16'd0}},
      // failed load burns pid 1
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b0, 1'b1,
        '{pts_pkg::ST_LOAD_FAIL, 16'd0, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd2, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'hFFFF, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd3, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd4, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd5, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd6, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd7, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd8, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_OK, 16'd9, 1'b0, 3'd0, 16'd0}},
      // table full, with and without load success
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b1,
        '{pts_pkg::ST_FULL, 16'd0, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b0, 1'b1,
        '{pts_pkg::ST_FULL, 16'd0, 1'b0, 3'd0, 16'd0}},
      '{pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0, 1'b1,
        '{pts_pkg::ST_OK, 16'd0, 1'b1, 3'd0, 16'd2}},
      '{pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0, 1'b0, '0},
      '{pts_pkg::ACT_DISPATCH, 16'h0000, 1'b0, 1'b0, '0},
      // running is not ready: schedule moves on
      '{pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0, 1'b0, '0},
      '{pts_pkg::ACT_KILL, 16'd3, 1'b0, 1'b0, '0},
      '{pts_pkg::ACT_KILL, 16'd3, 1'b0, 1'b0, '0},
      '{pts_pkg::ACT_CREATE, 16'h0000, 1'b1, 1'b0, '0},
      '{pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0, 1'b0, '0},
      '{pts_pkg::ACT_DISPATCH, 16'h0000, 1'b0, 1'b0, '0},
      '{pts_pkg::ACT_KILL, 16'd2, 1'b0, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      push_word(dir_rows[i].act, dir_rows[i].kpid, dir_rows[i].ok,
                dir_rows[i].typed, dir_rows[i].want);

    // sender waits for the pipe to empty
    drain();
    rest($urandom_range(1, 5));

    // random segments, each with its own create mix so the table fills and empties
    for (int seg = 0; seg < 18; seg++) begin
      if (seg == 9) begin
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        fast     = 1'b1;
        repeat (12) send_random_cmd(40);
        fast     = 1'b0;
      end
      repeat (50) send_random_cmd($urandom_range(10, 60));
    end

    // empty the table, then walk one process through every action
    fast = 1'b1;
    for (int i = 0; i < N_SLOTS; i++)
      if (tbl_used[i]) push_word(pts_pkg::ACT_KILL, tbl_pid[i], 1'b0);
    push_word(pts_pkg::ACT_CREATE, 16'($urandom_range(0, 65535)), 1'b1);
    keep_pid = tbl_pid[0];
    push_word(pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0);
    push_word(pts_pkg::ACT_DISPATCH, 16'hFFFF, 1'b1);
    // the only process is running, so the selection drops
    push_word(pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0);
    push_word(pts_pkg::ACT_KILL, 16'h0000, 1'b0);
    push_word(pts_pkg::ACT_KILL, 16'hFFFF, 1'b0);
    push_word(pts_pkg::ACT_KILL, keep_pid, 1'b0);
    push_word(pts_pkg::ACT_KILL, keep_pid, 1'b0);
    push_word(pts_pkg::ACT_SCHEDULE, 16'h0000, 1'b0);
    fast = 1'b0;
    repeat (30) send_random_cmd(35);

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pts_pkg.sv
src/pts_ctrl.sv
src/pts_dp.sv
src/process_table_scheduler.sv
dv/testbench.sv
